@@ src/gmce_pkg.sv @@
package gmce_pkg;

  localparam logic [1:0] FUNC_MSR_READ  = 2'd0;
  localparam logic [1:0] FUNC_MSR_WRITE = 2'd1;
  localparam logic [1:0] FUNC_CR0_WRITE = 2'd2;
  localparam logic [1:0] FUNC_XSETBV    = 2'd3;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_UNHANDLED = 2'd1;
  localparam logic [1:0] ST_GP        = 2'd2;
  localparam logic [1:0] ST_ERROR     = 2'd3;

  localparam logic [31:0] MSR_EFER       = 32'hc000_0080;
  localparam logic [31:0] MSR_PAT        = 32'h0000_0277;
  localparam logic [31:0] MSR_FEAT_CTRL  = 32'h0000_003a;
  localparam logic [31:0] MSR_MISC_EN    = 32'h0000_01a0;
  localparam logic [31:0] MSR_OSVW_LEN   = 32'hc001_0140;
  localparam logic [31:0] MSR_NB_CFG     = 32'hc001_001f;
  localparam logic [31:0] MSR_UCODE_REV  = 32'h0000_008b;

  localparam int EFER_LME_BIT  = 8;
  localparam int EFER_LMA_BIT  = 10;
  localparam int EFER_SVME_BIT = 12;
  localparam int CR0_ET_BIT    = 4;
  localparam int CR0_PG_BIT    = 31;

  localparam logic [63:0] PAT_RSVD_MASK   = 64'hF8F8_F8F8_F8F8_F8F8;
  localparam logic [63:0] PAT_RESET       = 64'h0007_0406_0001_0406;
  localparam logic [63:0] EFER_RESET      = 64'h0000_0000_0000_1000;
  localparam logic [63:0] CR0_RESET       = 64'h0000_0000_0001_0030;
  localparam logic [63:0] XCR0_RESET      = 64'h0000_0000_0000_0001;
  localparam logic [63:0] EFER_MASK_RESET = 64'h0000_0000_0000_0901;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] msr_index;
    logic [63:0] write_value;
    logic [31:0] xcr_index;
    logic        decode_valid;
    logic [1:0]  current_cpl;
  } access_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] read_value;
    logic        control_dirty;
  } result_t;

  function automatic logic pat_is_bad(input logic [63:0] v);
    logic bad;
    bad = |(v & PAT_RSVD_MASK);
    for (int k = 0; k < 8; k++) begin
      // Memory types 2 and 3 are reserved encodings.
      if (v[8*k+2 -: 2] == 2'b01) begin
        bad = 1'b1;
      end
    end
    return bad;
  endfunction

endpackage

@@ src/guest_msr_and_cr0_emulation_unit.sv @@
// A transaction accepted at the input moves from the input register to the result register.
// Throughput: one transaction per cycle unless out_ready stalls the result register; the path
// is an input register, one level of decode and mask logic on EFER, CR0, PAT and XCR0, and a
// result register. Reset (rst_n, synchronous, active low) empties both stages, loads the guest
// registers with their architectural reset values and the EFER write mask with 0x901.
module guest_msr_and_cr0_emulation_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_func,
  input  logic [31:0] in_msr_index,
  input  logic [63:0] in_write_value,
  input  logic [31:0] in_xcr_index,
  input  logic        in_decode_valid,
  input  logic [1:0]  in_current_cpl,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [63:0] out_read_value,
  output logic        out_control_dirty
);

  logic                 s1_valid_r;
  gmce_pkg::access_t    s1_r;
  logic                 out_valid_r;
  gmce_pkg::result_t    out_r;
  gmce_pkg::result_t    res_nxt;

  logic [63:0] efer_mask_r;
  logic [63:0] efer_r, efer_nxt;
  logic [63:0] cr0_r, cr0_nxt;
  logic [63:0] pat_r, pat_nxt;
  logic [63:0] xcr0_r, xcr0_nxt;

  logic s1_move;
  logic [63:0] efer_wr;

  assign s1_move  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_move;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_r.func         <= in_func;
      s1_r.msr_index    <= in_msr_index;
      s1_r.write_value  <= in_write_value;
      s1_r.xcr_index    <= in_xcr_index;
      s1_r.decode_valid <= in_decode_valid;
      s1_r.current_cpl  <= in_current_cpl;
    end
  end

  always_comb begin
    efer_wr = (s1_r.write_value & efer_mask_r);
    efer_wr[gmce_pkg::EFER_SVME_BIT] = 1'b1;
    efer_wr[gmce_pkg::EFER_LME_BIT]  = efer_wr[gmce_pkg::EFER_LME_BIT] |
                                       efer_r[gmce_pkg::EFER_LME_BIT];
    if (efer_wr[gmce_pkg::EFER_LME_BIT] && cr0_r[gmce_pkg::CR0_PG_BIT]) begin
      efer_wr[gmce_pkg::EFER_LMA_BIT] = 1'b1;
    end
  end

  always_comb begin
    efer_nxt = efer_r;
    cr0_nxt  = cr0_r;
    pat_nxt  = pat_r;
    xcr0_nxt = xcr0_r;
    res_nxt.status        = gmce_pkg::ST_DONE;
    res_nxt.read_value    = '0;
    res_nxt.control_dirty = 1'b0;
    unique case (s1_r.func)
      gmce_pkg::FUNC_MSR_READ: begin
        unique case (s1_r.msr_index)
          gmce_pkg::MSR_UCODE_REV, gmce_pkg::MSR_MISC_EN,
          gmce_pkg::MSR_OSVW_LEN, gmce_pkg::MSR_NB_CFG: begin
            res_nxt.read_value = '0;
          end
          gmce_pkg::MSR_FEAT_CTRL: begin
            res_nxt.read_value = 64'd1;
          end
          gmce_pkg::MSR_PAT: begin
            res_nxt.read_value = pat_r;
          end
          gmce_pkg::MSR_EFER: begin
            res_nxt.read_value = efer_r;
            res_nxt.read_value[gmce_pkg::EFER_SVME_BIT] = 1'b0;
          end
          default: begin
            res_nxt.status = gmce_pkg::ST_UNHANDLED;
          end
        endcase
      end
      gmce_pkg::FUNC_MSR_WRITE: begin
        unique case (s1_r.msr_index)
          gmce_pkg::MSR_PAT: begin
            if (gmce_pkg::pat_is_bad(s1_r.write_value)) begin
              res_nxt.status = gmce_pkg::ST_GP;
            end else begin
              pat_nxt = s1_r.write_value;
            end
          end
          gmce_pkg::MSR_EFER: begin
            efer_nxt = efer_wr;
            res_nxt.control_dirty = 1'b1;
          end
          gmce_pkg::MSR_NB_CFG: begin
            res_nxt.status = gmce_pkg::ST_DONE;
          end
          default: begin
            res_nxt.status = gmce_pkg::ST_UNHANDLED;
          end
        endcase
      end
      gmce_pkg::FUNC_CR0_WRITE: begin
        if (!s1_r.decode_valid) begin
          // LMSW carries no decode information and is not emulated here.
          res_nxt.status = gmce_pkg::ST_ERROR;
        end else begin
          cr0_nxt = s1_r.write_value;
          cr0_nxt[gmce_pkg::CR0_ET_BIT] = 1'b1;
          res_nxt.control_dirty = 1'b1;
          if (efer_r[gmce_pkg::EFER_LME_BIT] &&
              (s1_r.write_value[gmce_pkg::CR0_PG_BIT] != cr0_r[gmce_pkg::CR0_PG_BIT])) begin
            efer_nxt[gmce_pkg::EFER_LMA_BIT] = s1_r.write_value[gmce_pkg::CR0_PG_BIT];
          end
        end
      end
      gmce_pkg::FUNC_XSETBV: begin
        if (s1_r.current_cpl == 2'd0) begin
          if (s1_r.xcr_index == 32'd0) begin
            xcr0_nxt = s1_r.write_value;
          end else begin
            res_nxt.status = gmce_pkg::ST_ERROR;
          end
        end
      end
      default: begin
        res_nxt.status = gmce_pkg::ST_ERROR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      efer_mask_r <= gmce_pkg::EFER_MASK_RESET;
      efer_r      <= gmce_pkg::EFER_RESET;
      cr0_r       <= gmce_pkg::CR0_RESET;
      pat_r       <= gmce_pkg::PAT_RESET;
      xcr0_r      <= gmce_pkg::XCR0_RESET;
    end else begin
      if (cfg_we) begin
        efer_mask_r <= cfg_wdata;
      end
      if (s1_move) begin
        efer_r <= efer_nxt;
        cr0_r  <= cr0_nxt;
        pat_r  <= pat_nxt;
        xcr0_r <= xcr0_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_ready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_r.status;
  assign out_read_value    = out_r.read_value;
  assign out_control_dirty = out_r.control_dirty;

  // SVME is forced on every EFER update and must never drop.
  a_svme_kept: assert property (@(posedge clk) disable iff (!rst_n)
    efer_r[gmce_pkg::EFER_SVME_BIT])
    else $error("EFER.SVME cleared");

  // CR0.ET is forced on every CR0 write.
  a_et_kept: assert property (@(posedge clk) disable iff (!rst_n)
    cr0_r[gmce_pkg::CR0_ET_BIT])
    else $error("CR0.ET cleared");

  // LME is sticky once a guest has set it.
  a_lme_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    efer_r[gmce_pkg::EFER_LME_BIT] |=> efer_r[gmce_pkg::EFER_LME_BIT])
    else $error("EFER.LME cleared");

  // Only a completed access can report a control register update.
  a_dirty_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.control_dirty) |-> (out_r.status == gmce_pkg::ST_DONE))
    else $error("control_dirty with non-done status");

  // A failed access returns no read data.
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status != gmce_pkg::ST_DONE)) |-> (out_r.read_value == '0))
    else $error("read data on failed access");

  // A stalled result register holds its transaction.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |=> (out_valid_r && $stable(out_r)))
    else $error("result changed while stalled");

endmodule
